### rtl/lbm_d2q9_boundary_engine_unit_defines.svh
// Assertion macros for the boundary engine checker.
`ifndef LBM_D2Q9_BOUNDARY_ENGINE_UNIT_DEFINES_SVH
`define LBM_D2Q9_BOUNDARY_ENGINE_UNIT_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define LBM_ASSERT_SAME(label, cond, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error("boundary engine check failed");

// Check that a condition implies a consequence in the next cycle.
`define LBM_ASSERT_NEXT(label, cond, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error("boundary engine check failed");

`endif

### rtl/lbm_pkg.sv
// Package: types, codes, direction tables and helpers of the boundary engine.
`default_nettype none
package lbm_pkg;

   localparam int POP_W         = 24;
   localparam int FRAC_W        = 20;
   localparam int NODES_DEFAULT = 4096;
   localparam int DIRS          = 9;
   localparam int SUM_W         = 29;
   localparam int DEN_W         = 26;
   localparam int DIVIDEND_W    = 50;
   localparam int DIVISOR_W     = 25;
   localparam int PROD_W        = 48;
   localparam int T_W           = 52;
   localparam int Z_W           = 32;
   localparam int Q_W           = 31;

   // Operation modes
   localparam logic [2:0] MODE_WRITE  = 3'd0;
   localparam logic [2:0] MODE_READ   = 3'd1;
   localparam logic [2:0] MODE_BOUNCE = 3'd2;
   localparam logic [2:0] MODE_LEFT   = 3'd3;
   localparam logic [2:0] MODE_RIGHT  = 3'd4;
   localparam logic [2:0] MODE_UPPER  = 3'd5;
   localparam logic [2:0] MODE_LOWER  = 3'd6;
   localparam logic [2:0] MODE_OPEN   = 3'd7;

   // Datapath commands
   localparam logic [3:0] OP_IDLE  = 4'd0;
   localparam logic [3:0] OP_LOAD  = 4'd1;
   localparam logic [3:0] OP_RD    = 4'd2;
   localparam logic [3:0] OP_WR    = 4'd3;
   localparam logic [3:0] OP_SUM   = 4'd4;
   localparam logic [3:0] OP_DIVGO = 4'd5;
   localparam logic [3:0] OP_RHO   = 4'd6;
   localparam logic [3:0] OP_MUL   = 4'd7;
   localparam logic [3:0] OP_TCALC = 4'd8;
   localparam logic [3:0] OP_TABS  = 4'd9;
   localparam logic [3:0] OP_TMUL  = 4'd10;
   localparam logic [3:0] OP_TWR   = 4'd11;
   localparam logic [3:0] OP_RSP   = 4'd12;

   // Wall table column offsets
   localparam logic [3:0] COL_INPLANE = 4'd0;
   localparam logic [3:0] COL_LEAVING = 4'd3;
   localparam logic [3:0] COL_SRC     = 4'd6;
   localparam logic [3:0] COL_DST     = 4'd9;
   localparam logic [3:0] COL_B       = 4'd12;
   localparam logic [3:0] COL_C       = 4'd13;

   typedef struct packed {
      logic [2:0]        mode;
      logic [11:0]       node;
      logic [11:0]       neighbor;
      logic [3:0]        slot;
      logic signed [23:0] value;
      logic signed [23:0] ux_velocity;
      logic signed [23:0] uy_velocity;
      logic              last_node;
   } req_type;

   typedef struct packed {
      logic signed [23:0] read_value;
      logic signed [23:0] density;
      logic              status;
      logic              list_done;
   } rsp_type;

   typedef struct packed {
      logic [3:0] op;
      logic [3:0] idx;
   } cmd_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       node_ok;
      logic       nb_ok;
      logic       slot_ok;
      logic       d_pos;
      logic       div_done;
   } stat_type;

   localparam logic [3:0] OPP_DIR [DIRS] = '{4'd0, 4'd3, 4'd4, 4'd1, 4'd2,
                                             4'd7, 4'd8, 4'd5, 4'd6};

   // Per wall: in-plane, leaving, source, destination, b, c
   localparam logic [3:0] WALL_DIRS [4][14] = '{
      '{4'd0, 4'd2, 4'd4, 4'd3, 4'd6, 4'd7, 4'd7, 4'd6, 4'd3, 4'd5, 4'd8, 4'd1, 4'd4, 4'd2},
      '{4'd0, 4'd2, 4'd4, 4'd1, 4'd5, 4'd8, 4'd8, 4'd5, 4'd1, 4'd6, 4'd7, 4'd3, 4'd4, 4'd2},
      '{4'd0, 4'd3, 4'd1, 4'd6, 4'd2, 4'd5, 4'd5, 4'd6, 4'd2, 4'd7, 4'd8, 4'd4, 4'd1, 4'd3},
      '{4'd0, 4'd3, 4'd1, 4'd8, 4'd4, 4'd7, 4'd8, 4'd7, 4'd4, 4'd6, 4'd5, 4'd2, 4'd1, 4'd3}
   };

   // Directions copied in right-open mode
   function automatic logic [3:0] open_dir(input logic [1:0] k);
      logic [3:0] r;
      case (k)
         2'd0:    r = 4'd3;
         2'd1:    r = 4'd6;
         default: r = 4'd7;
      endcase
      return r;
   endfunction

   // Apply sign to a magnitude and clamp to the population range
   function automatic logic signed [POP_W-1:0] sat_mag(input logic [DIVIDEND_W-1:0] mag,
                                                       input logic neg);
      logic signed [POP_W-1:0] r;
      if (neg) begin
         if (mag >= (DIVIDEND_W'(1) << (POP_W-1))) r = {1'b1, {(POP_W-1){1'b0}}};
         else r = -signed'(POP_W'(mag));
      end else begin
         if (mag > ((DIVIDEND_W'(1) << (POP_W-1)) - DIVIDEND_W'(1)))
            r = {1'b0, {(POP_W-1){1'b1}}};
         else r = signed'(POP_W'(mag));
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### rtl/lbm_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module lbm_div import lbm_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       busy,
   output logic [DIVIDEND_W-1:0]      quotient
);
   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in, dvs_ff, dvs_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   // Shift in one dividend bit, subtract when the divisor fits
   always_comb begin
      trial  = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits   = trial >= {1'b0, dvs_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? DIVISOR_W'(trial - {1'b0, dvs_ff}) : DIVISOR_W'(trial);
         cnt_in = cnt_ff - CNT_W'(1);
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

### rtl/lbm_dpath.sv
// Datapath: population store, gather registers and Zou-He arithmetic.
`default_nettype none
module lbm_dpath import lbm_pkg::*; #(
   parameter int NODES = NODES_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_item,
   input  wire cmd_type cmd,
   output stat_type     stat,
   output rsp_type      rsp_item
);
   localparam int DEPTH  = NODES * DIRS;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [POP_W-1:0]        mem [DEPTH];
   logic [POP_W-1:0]        mem_q_ff;
   req_type                 req_ff;
   logic signed [POP_W-1:0] f_ff [DIRS];
   logic                    rd_pend_ff;
   logic [3:0]              rd_dir_ff;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [POP_W-1:0] rho_ff;
   logic signed [PROD_W-1:0] pn_ff, pt_ff;
   logic signed [T_W-1:0]   t_ff, t_in;
   logic                    neg_ff;
   logic [Z_W-1:0]          z_ff;
   logic [Q_W-1:0]          q_ff;
   rsp_type                 rsp_ff;

   logic [1:0]              wall;
   logic                    norm_x, sn_neg, st_neg, zou_mode;
   logic signed [POP_W-1:0] un, ut;
   logic signed [DEN_W-1:0] den;
   logic [ADDR_W-1:0]       node_base, nb_base, addr;
   logic                    mem_we, mem_re;
   logic [POP_W-1:0]        wdata;
   logic [3:0]              dir;
   logic [1:0]              k;
   logic [DIVIDEND_W-1:0]   dividend, quotient;
   logic [SUM_W-1:0]        sum_mag;
   logic                    div_busy;
   logic signed [T_W-1:0]   fse, dd, rn, rt3, rt, f6, d3, pte;
   logic [T_W-1:0]          tmag, yv;
   logic [2*Z_W-1:0]        prod;
   logic signed [POP_W-1:0] t_sat;

   // Decode the wall geometry from the mode
   always_comb begin
      wall     = 2'(req_ff.mode - MODE_LEFT);
      zou_mode = req_ff.mode inside {[MODE_LEFT:MODE_LOWER]};
      norm_x   = (wall == 2'd0) || (wall == 2'd1);
      sn_neg   = (wall == 2'd1) || (wall == 2'd2);
      st_neg   = (wall == 2'd2) || (wall == 2'd3);
      un       = norm_x ? req_ff.ux_velocity : req_ff.uy_velocity;
      ut       = norm_x ? req_ff.uy_velocity : req_ff.ux_velocity;
      den      = sn_neg ? (DEN_W'(1) <<< FRAC_W) + DEN_W'(un)
                        : (DEN_W'(1) <<< FRAC_W) - DEN_W'(un);
      k        = cmd.idx[1:0];
   end

   // Status toward the controller
   always_comb begin
      stat.mode     = req_ff.mode;
      stat.node_ok  = 32'(req_ff.node) < NODES;
      stat.nb_ok    = 32'(req_ff.neighbor) < NODES;
      stat.slot_ok  = req_ff.slot < 4'(DIRS);
      stat.d_pos    = den > 0;
      stat.div_done = !div_busy;
   end

   // Form the store address and write data for the current command
   always_comb begin
      node_base = ADDR_W'(32'(req_ff.node) * 32'(DIRS));
      nb_base   = ADDR_W'(32'(req_ff.neighbor) * 32'(DIRS));
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      wdata     = '0;
      dir       = cmd.idx;
      addr      = node_base;
      case (cmd.op)
         OP_RD: begin
            mem_re = 1'b1;
            if (req_ff.mode == MODE_READ) dir = req_ff.slot;
            else if (req_ff.mode == MODE_OPEN) dir = open_dir(k);
            addr = ((req_ff.mode == MODE_OPEN) ? nb_base : node_base) + ADDR_W'(dir);
         end
         OP_WR: begin
            mem_we = 1'b1;
            if (req_ff.mode == MODE_WRITE) begin
               dir   = req_ff.slot;
               wdata = req_ff.value;
            end else if (req_ff.mode == MODE_OPEN) begin
               dir   = open_dir(k);
               wdata = f_ff[dir];
            end else begin
               wdata = f_ff[OPP_DIR[cmd.idx]];
            end
            addr = node_base + ADDR_W'(dir);
         end
         OP_TWR: begin
            mem_we = 1'b1;
            dir    = WALL_DIRS[wall][COL_DST + 4'(k)];
            wdata  = t_sat;
            addr   = node_base + ADDR_W'(dir);
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // Single-port store with registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[addr] <= wdata;
      if (mem_re) mem_q_ff <= mem[addr];
   end

   // Track the outstanding read and capture its data
   always_ff @(posedge clock) begin
      if (reset) rd_pend_ff <= 1'b0;
      else rd_pend_ff <= mem_re;
      rd_dir_ff <= dir;
      if (rd_pend_ff) f_ff[rd_dir_ff] <= signed'(mem_q_ff);
      if (cmd.op == OP_LOAD) req_ff <= req_item;
   end

   // Weighted population sum for the wall density
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < 3; i++) begin
         sum_in = sum_in + SUM_W'(f_ff[WALL_DIRS[wall][COL_INPLANE + 4'(i)]])
                + (SUM_W'(f_ff[WALL_DIRS[wall][COL_LEAVING + 4'(i)]]) <<< 1);
      end
   end

   // Density dividend: |sum| scaled, plus half the divisor for rounding
   assign sum_mag  = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign dividend = (DIVIDEND_W'(sum_mag) << FRAC_W) + DIVIDEND_W'(den[DEN_W-1:1]);

   lbm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == OP_DIVGO),
      .dividend (dividend),
      .divisor  (den[DIVISOR_W-1:0]),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // Numerator of one unknown population, over six times one
   always_comb begin
      fse = T_W'(f_ff[WALL_DIRS[wall][COL_SRC + 4'(k)]]);
      dd  = T_W'(f_ff[WALL_DIRS[wall][COL_B]]) - T_W'(f_ff[WALL_DIRS[wall][COL_C]]);
      f6  = (fse <<< (FRAC_W + 2)) + (fse <<< (FRAC_W + 1));
      d3  = (dd <<< (FRAC_W + 1)) + (dd <<< FRAC_W);
      rn  = sn_neg ? -T_W'(pn_ff) : T_W'(pn_ff);
      pte = T_W'(pt_ff);
      rt3 = (pte <<< 1) + pte;
      rt  = st_neg ? -rt3 : rt3;
      case (k)
         2'd0:    t_in = f6 + d3 + rn + rt;
         2'd1:    t_in = f6 - d3 + rn - rt;
         default: t_in = f6 + (rn <<< 2);
      endcase
      tmag  = t_ff[T_W-1] ? T_W'(-t_ff) : T_W'(t_ff);
      yv    = (tmag + (T_W'(3) << FRAC_W)) >> FRAC_W;
      prod  = (2*Z_W)'(z_ff) * (2*Z_W)'(32'hAAAA_AAAB);
      t_sat = sat_mag(DIVIDEND_W'(q_ff), neg_ff);
   end

   // Arithmetic registers, each loaded by its own command
   always_ff @(posedge clock) begin
      if (cmd.op == OP_SUM) sum_ff <= sum_in;
      if (cmd.op == OP_RHO) rho_ff <= sat_mag(quotient, sum_ff[SUM_W-1]);
      if (cmd.op == OP_MUL) begin
         pn_ff <= rho_ff * un;
         pt_ff <= rho_ff * ut;
      end
      if (cmd.op == OP_TCALC) t_ff <= t_in;
      if (cmd.op == OP_TABS) begin
         neg_ff <= t_ff[T_W-1];
         z_ff   <= Z_W'(yv >> 1);
      end
      if (cmd.op == OP_TMUL) q_ff <= prod[2*Z_W-1:33];
   end

   // Build the result transaction
   always_ff @(posedge clock) begin
      if (cmd.op == OP_RSP) begin
         rsp_ff.read_value <= (req_ff.mode == MODE_READ && stat.node_ok && stat.slot_ok)
                              ? f_ff[req_ff.slot] : '0;
         rsp_ff.density    <= (zou_mode && stat.node_ok && stat.d_pos) ? rho_ff : '0;
         rsp_ff.status     <= zou_mode && stat.node_ok && !stat.d_pos;
         rsp_ff.list_done  <= req_ff.last_node;
      end
   end

   assign rsp_item = rsp_ff;
endmodule
`default_nettype wire

### rtl/lbm_ctrl.sv
// Controller: sequences reads, writes and arithmetic for one transaction.
`default_nettype none
module lbm_ctrl import lbm_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire stat_type stat,
   output logic          busy,
   output logic          rsp_valid,
   output cmd_type       cmd
);
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DISP   = 4'd1;
   localparam logic [3:0] S_READ   = 4'd2;
   localparam logic [3:0] S_RDLAST = 4'd3;
   localparam logic [3:0] S_WRITE  = 4'd4;
   localparam logic [3:0] S_SUM    = 4'd5;
   localparam logic [3:0] S_DIVGO  = 4'd6;
   localparam logic [3:0] S_DIV    = 4'd7;
   localparam logic [3:0] S_RHO    = 4'd8;
   localparam logic [3:0] S_MUL    = 4'd9;
   localparam logic [3:0] S_TCALC  = 4'd10;
   localparam logic [3:0] S_TABS   = 4'd11;
   localparam logic [3:0] S_TMUL   = 4'd12;
   localparam logic [3:0] S_TWR    = 4'd13;
   localparam logic [3:0] S_RESP   = 4'd14;

   logic [3:0] state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [3:0] n_rd, n_wr;
   logic       zou_mode;

   // Access counts per mode
   always_comb begin
      zou_mode = stat.mode inside {[MODE_LEFT:MODE_LOWER]};
      case (stat.mode)
         MODE_READ: n_rd = 4'd1;
         MODE_OPEN: n_rd = 4'd3;
         default:   n_rd = 4'(DIRS);
      endcase
      case (stat.mode)
         MODE_WRITE: n_wr = 4'd1;
         MODE_OPEN:  n_wr = 4'd3;
         default:    n_wr = 4'(DIRS);
      endcase
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd.op   = OP_IDLE;
      cmd.idx  = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = OP_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            cnt_in   = '0;
            state_in = S_RESP;
            if (stat.node_ok) begin
               case (stat.mode)
                  MODE_WRITE: if (stat.slot_ok) state_in = S_WRITE;
                  MODE_READ:  if (stat.slot_ok) state_in = S_READ;
                  MODE_BOUNCE: state_in = S_READ;
                  MODE_OPEN:  if (stat.nb_ok) state_in = S_READ;
                  default:    if (stat.d_pos) state_in = S_READ;
               endcase
            end
         end
         S_READ: begin
            cmd.op = OP_RD;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == n_rd - 4'd1) state_in = S_RDLAST;
         end
         S_RDLAST: begin
            cnt_in = '0;
            if (stat.mode == MODE_READ) state_in = S_RESP;
            else if (zou_mode) state_in = S_SUM;
            else state_in = S_WRITE;
         end
         S_WRITE: begin
            cmd.op = OP_WR;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == n_wr - 4'd1) state_in = S_RESP;
         end
         S_SUM: begin
            cmd.op   = OP_SUM;
            state_in = S_DIVGO;
         end
         S_DIVGO: begin
            cmd.op   = OP_DIVGO;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (stat.div_done) state_in = S_RHO;
         end
         S_RHO: begin
            cmd.op   = OP_RHO;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.op   = OP_MUL;
            cnt_in   = '0;
            state_in = S_TCALC;
         end
         S_TCALC: begin
            cmd.op   = OP_TCALC;
            state_in = S_TABS;
         end
         S_TABS: begin
            cmd.op   = OP_TABS;
            state_in = S_TMUL;
         end
         S_TMUL: begin
            cmd.op   = OP_TMUL;
            state_in = S_TWR;
         end
         S_TWR: begin
            cmd.op = OP_TWR;
            cnt_in = cnt_ff + 4'd1;
            state_in = (cnt_ff == 4'd2) ? S_RESP : S_TCALC;
         end
         S_RESP: begin
            cmd.op   = OP_RSP;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = (state_ff == S_RESP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

### rtl/lbm_d2q9_boundary_engine_unit.sv
// Top level of the D2Q9 Zou-He boundary engine.
//
// Usage: drive req_item and raise start; the transaction is taken at a clock
// edge where start is high and busy is low. Exactly one result follows on
// rsp_item, marked by a one-cycle rsp_valid strobe; the receiver must take it
// in that cycle, it cannot hold results off.
// A rejected node or a non-positive divisor skips all store accesses and
// arithmetic. One transaction is in flight at a time; the next may be
// accepted in the strobe cycle.
// The Zou-He time is set by the density divider, one quotient bit per cycle
// over 50 bits, plus nine reads and three writes through the single store
// port. Populations live in a single-port store of NODES*9 words.
// Reset clears the controller, result strobe, read flag and divider state;
// the store holds whatever was written and is undefined until then.
`default_nettype none
module lbm_d2q9_boundary_engine_unit import lbm_pkg::*; #(
   parameter int NODES = NODES_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_valid,
   output rsp_type      rsp_item
);
   cmd_type  cmd;
   stat_type stat;

   lbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   lbm_dpath #(.NODES(NODES)) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_item (rsp_item)
   );
endmodule
`default_nettype wire

### rtl/lbm_checker.sv
// Port-level checker for the boundary engine, bound to the top level.
`default_nettype none
`include "lbm_d2q9_boundary_engine_unit_defines.svh"
module lbm_checker import lbm_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_item
);
   // An accepted transaction makes the block busy
   `LBM_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   // A result only closes a transaction that was in progress
   `LBM_ASSERT_SAME(a_rsp_after_busy, rsp_valid, $past(busy) && !busy)
   // One strobe per transaction
   `LBM_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid)
   // A rejected divisor reports no density and no read data
   `LBM_ASSERT_SAME(a_status_zero, rsp_valid && rsp_item.status,
                    rsp_item.density == 0 && rsp_item.read_value == 0)
endmodule

bind lbm_d2q9_boundary_engine_unit lbm_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
`default_nettype wire

### bench/testbench.sv
// Self-checking testbench for the D2Q9 Zou-He boundary engine.
`default_nettype none
module testbench;
   import lbm_pkg::*;

   localparam int  NODE_COUNT = 4096;
   localparam longint FX_ONE  = 64'sd1 << 20;
   localparam int  CYCLE_LIMIT = 900000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;

   lbm_d2q9_boundary_engine_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Wall geometry per Zou-He mode: left, right, upper, lower
   int wall_inplane [4][3] = '{'{0,2,4}, '{0,2,4}, '{0,3,1}, '{0,3,1}};
   int wall_leaving [4][3] = '{'{3,6,7}, '{1,5,8}, '{6,2,5}, '{8,4,7}};
   int wall_dst     [4][3] = '{'{5,8,1}, '{6,7,3}, '{7,8,4}, '{6,5,2}};
   int wall_src     [4][3] = '{'{7,6,3}, '{8,5,1}, '{5,6,2}, '{8,7,4}};
   int wall_b       [4]    = '{4, 4, 1, 1};
   int wall_c       [4]    = '{2, 2, 3, 3};
   bit wall_normal_x[4]    = '{1'b1, 1'b1, 1'b0, 1'b0};
   int wall_sn      [4]    = '{1, -1, -1, 1};
   int wall_st      [4]    = '{1, 1, -1, -1};
   int opposite     [9]    = '{0, 3, 4, 1, 2, 7, 8, 5, 6};

   logic signed [23:0] pop_store [NODE_COUNT*9];
   bit [8:0]           written_mask [NODE_COUNT];

   req_type pending_items [$];
   bit      drain_first [$];
   rsp_type expected_rsp [$];

   int   errors = 0;
   int   items_sent = 0;
   int   rsp_seen = 0;
   int   zou_he_ok = 0;
   int   zou_he_rejected = 0;
   int   cycles = 0;
   bit   stim_done = 1'b0;

   function automatic longint div_nearest(longint n, longint d);
      longint m, q;
      m = (n < 0) ? -n : n;
      q = (m + d / 2) / d;
      return (n < 0) ? -q : q;
   endfunction

   function automatic logic signed [23:0] clamp_pop(longint v);
      if (v > 64'sd8388607) return 24'sh7FFFFF;
      if (v < -64'sd8388608) return 24'sh800000;
      return v[23:0];
   endfunction

   // Apply one transaction to the shadow store and return the expected response
   function automatic rsp_type predict_boundary(req_type r);
      rsp_type  e;
      int       base, sb, w, i;
      longint   un, ut, d, sum, rho, rn, rt;
      longint   f [9];
      longint   t [3];
      logic signed [23:0] tmp [9];
      e = '0;
      e.list_done = r.last_node;
      base = int'(r.node) * 9;
      case (r.mode)
         MODE_WRITE: if (r.slot < 9) pop_store[base + r.slot] = r.value;
         MODE_READ:  if (r.slot < 9) e.read_value = pop_store[base + r.slot];
         MODE_BOUNCE: begin
            for (i = 0; i < 9; i++) tmp[i] = pop_store[base + opposite[i]];
            for (i = 0; i < 9; i++) pop_store[base + i] = tmp[i];
         end
         MODE_OPEN: begin
            sb = int'(r.neighbor) * 9;
            pop_store[base + 3] = pop_store[sb + 3];
            pop_store[base + 6] = pop_store[sb + 6];
            pop_store[base + 7] = pop_store[sb + 7];
         end
         default: begin
            w  = int'(r.mode) - int'(MODE_LEFT);
            un = wall_normal_x[w] ? longint'(r.ux_velocity) : longint'(r.uy_velocity);
            ut = wall_normal_x[w] ? longint'(r.uy_velocity) : longint'(r.ux_velocity);
            d  = FX_ONE - wall_sn[w] * un;
            if (d <= 0) begin
               e.status = 1'b1;
               zou_he_rejected++;
            end else begin
               for (i = 0; i < 9; i++) f[i] = longint'(pop_store[base + i]);
               sum = 0;
               for (i = 0; i < 3; i++)
                  sum += f[wall_inplane[w][i]] + 2 * f[wall_leaving[w][i]];
               rho = longint'(clamp_pop(div_nearest(sum * FX_ONE, d)));
               rn = wall_sn[w] * rho * un;
               rt = wall_st[w] * 3 * rho * ut;
               t[0] = 6 * FX_ONE * f[wall_src[w][0]]
                      + 3 * FX_ONE * (f[wall_b[w]] - f[wall_c[w]]) + rn + rt;
               t[1] = 6 * FX_ONE * f[wall_src[w][1]]
                      + 3 * FX_ONE * (f[wall_c[w]] - f[wall_b[w]]) + rn - rt;
               t[2] = 6 * FX_ONE * f[wall_src[w][2]] + 4 * rn;
               for (i = 0; i < 3; i++)
                  pop_store[base + wall_dst[w][i]] = clamp_pop(div_nearest(t[i], 6 * FX_ONE));
               e.density = rho[23:0];
               zou_he_ok++;
            end
         end
      endcase
      return e;
   endfunction

   // Queue one transaction; track which store entries become defined
   task automatic queue_item(input req_type r, input bit drain);
      pending_items.push_back(r);
      drain_first.push_back(drain);
      if (r.mode == MODE_WRITE && r.slot < 9) written_mask[r.node][r.slot] = 1'b1;
      if (r.mode == MODE_OPEN) written_mask[r.node] |= 9'b0_1100_1000;
   endtask

   function automatic req_type blank_item(logic [2:0] m, logic [11:0] n);
      req_type r;
      r.mode        = m;
      r.node        = n;
      r.neighbor    = 12'($urandom);
      r.slot        = 4'($urandom_range(0, 8));
      r.value       = 24'($urandom);
      r.ux_velocity = 24'($urandom);
      r.uy_velocity = 24'($urandom);
      r.last_node   = 1'($urandom);
      return r;
   endfunction

   function automatic logic signed [23:0] rand_population();
      if ($urandom_range(0, 9) < 7) return 24'($urandom_range(0, 400000));
      return 24'($urandom);
   endfunction

   function automatic logic signed [23:0] rand_velocity();
      int k;
      k = $urandom_range(0, 19);
      if (k < 14) return 24'($signed($urandom_range(0, 420000)) - 210000);
      if (k == 14) return 24'sh100000;
      if (k == 15) return -24'sh100000;
      return 24'($urandom);
   endfunction

   function automatic logic [11:0] rand_node();
      if ($urandom_range(0, 19) == 0) return 12'($urandom);
      if ($urandom_range(0, 19) == 0) return 12'd4095;
      return 12'($urandom_range(0, 15));
   endfunction

   // Fill all nine populations of a node
   task automatic fill_node(input logic [11:0] n);
      req_type r;
      for (int s = 0; s < 9; s++) begin
         r = blank_item(MODE_WRITE, n);
         r.slot  = 4'(s);
         r.value = rand_population();
         queue_item(r, 1'b0);
      end
   endtask

   // Build one operation on a node that is already fully defined
   task automatic node_operation(input logic [11:0] n);
      req_type r;
      logic [11:0] nb;
      r = blank_item(3'($urandom_range(0, 7)), n);
      r.ux_velocity = rand_velocity();
      r.uy_velocity = rand_velocity();
      r.value = rand_population();
      if (r.mode == MODE_READ && $urandom_range(0, 9) == 0) r.slot = 4'($urandom_range(9, 15));
      if (r.mode == MODE_WRITE && $urandom_range(0, 9) == 0) r.slot = 4'($urandom_range(9, 15));
      if (r.mode == MODE_OPEN) begin
         nb = rand_node();
         if ((written_mask[nb] & 9'b0_1100_1000) != 9'b0_1100_1000) nb = n;
         r.neighbor = nb;
      end
      queue_item(r, $urandom_range(0, 99) == 0);
   endtask

   task automatic directed_items();
      req_type r;
      logic signed [23:0] extremes [9] = '{24'sh7FFFFF, 24'sh800000, 24'sh000000,
         24'shFFFFFF, 24'sh100000, 24'sh555555, 24'shAAAAAA, 24'sh000001, 24'sh0F0F0F};
      for (int s = 0; s < 9; s++) begin
         r = blank_item(MODE_WRITE, 12'd0);
         r.slot = 4'(s);
         r.value = extremes[s];
         queue_item(r, 1'b0);
      end
      // Write to a slot above eight is dropped, read of one returns zero
      r = blank_item(MODE_WRITE, 12'd0); r.slot = 4'd15; queue_item(r, 1'b0);
      r = blank_item(MODE_READ, 12'd0);  r.slot = 4'd12; queue_item(r, 1'b0);
      r = blank_item(MODE_READ, 12'd0);  r.slot = 4'd1;  queue_item(r, 1'b0);
      r = blank_item(MODE_BOUNCE, 12'd0); queue_item(r, 1'b0);
      fill_node(12'd4095);
      // One Zou-He per wall with zero and small velocity
      for (int m = 3; m <= 6; m++) begin
         r = blank_item(3'(m), 12'd4095);
         r.ux_velocity = (m == 3) ? 24'sd0 : 24'sd104857;
         r.uy_velocity = -24'sd52428;
         queue_item(r, 1'b0);
      end
      // Divisor exactly zero and negative
      r = blank_item(MODE_LEFT, 12'd4095);  r.ux_velocity = 24'sh100000; queue_item(r, 1'b0);
      r = blank_item(MODE_RIGHT, 12'd4095); r.ux_velocity = 24'sh800000; queue_item(r, 1'b0);
      r = blank_item(MODE_UPPER, 12'd4095); r.uy_velocity = 24'sh800000; queue_item(r, 1'b0);
      r = blank_item(MODE_LOWER, 12'd4095); r.uy_velocity = 24'sh7FFFFF; queue_item(r, 1'b1);
      r = blank_item(MODE_OPEN, 12'd5); r.neighbor = 12'd0; queue_item(r, 1'b0);
      r = blank_item(MODE_READ, 12'd5); r.slot = 4'd6; queue_item(r, 1'b0);
   endtask

   // Driver: accept on start && !busy, then launch the next transaction or idle
   always @(posedge clock) begin
      logic    accepted;
      int      idle_pct;
      rsp_type e;
      if (reset) begin
         start <= 1'b0;
      end else begin
         accepted = start && !busy;
         if (accepted) begin
            e = predict_boundary(req_item);
            expected_rsp.push_back(e);
            items_sent++;
         end
         if (!start || accepted) begin
            case ((items_sent / 150) % 4)
               1:       idle_pct = 47;
               3:       idle_pct = 11;
               default: idle_pct = 0;
            endcase
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct &&
                !(drain_first[0] && (expected_rsp.size() != 0))) begin
               req_item <= pending_items.pop_front();
               void'(drain_first.pop_front());
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each strobed result with the oldest expectation
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         rsp_seen++;
         if (expected_rsp.size() == 0) begin
            $error("unexpected transaction: read_value %0d density %0d",
                   rsp_item.read_value, rsp_item.density);
            errors++;
         end else begin
            e = expected_rsp.pop_front();
            if (rsp_item.read_value !== e.read_value) begin
               $error("read_value expected %0d actual %0d", e.read_value, rsp_item.read_value);
               errors++;
            end
            if (rsp_item.density !== e.density) begin
               $error("density expected %0d actual %0d", e.density, rsp_item.density);
               errors++;
            end
            if (rsp_item.status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_item.status);
               errors++;
            end
            if (rsp_item.list_done !== e.list_done) begin
               $error("list_done expected %0d actual %0d", e.list_done, rsp_item.list_done);
               errors++;
            end
         end
      end
   end

   // Timeout guard
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("testbench: FAIL");
         $finish;
      end
   end

   initial begin
      logic [11:0] n;
      int ops;
      for (int i = 0; i < NODE_COUNT; i++) written_mask[i] = '0;
      directed_items();
      // Random part: mostly fill-then-operate sequences, plus stray reads/writes
      while (pending_items.size() < 1220) begin
         n = rand_node();
         if (written_mask[n] != 9'h1FF || $urandom_range(0, 3) == 0) fill_node(n);
         ops = $urandom_range(1, 6);
         for (int k = 0; k < ops; k++) node_operation(n);
         if ($urandom_range(0, 49) == 0) queue_item(pending_items[$], 1'b1);
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait (pending_items.size() == 0 && !start);
      wait (expected_rsp.size() == 0);
      repeat (200) @(posedge clock);
      if (expected_rsp.size() != 0) begin
         $error("%0d expected transactions never arrived", expected_rsp.size());
         errors++;
      end
      $display("covered %0d transactions, %0d results; Zou-He solved %0d, rejected %0d",
               items_sent, rsp_seen, zou_he_ok, zou_he_rejected);
      $display("idle phases of 0, 47 and 11 percent; %0d mismatches", errors);
      if (errors == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end
endmodule
`default_nettype wire
